### design/msr_pkg.sv
// shared types, constants and field widths for the multi-source summer
// no dependencies; imported by every module of the block except msr_ram
package msr_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SUM_W           = 19;
    localparam int MAX_SOURCES     = 8;
    localparam int SRC_W           = 3;
    localparam int CH_W            = 2;
    localparam int POS_W           = 10;
    localparam int NS_W            = 4;
    localparam int ENERGY_W        = 64;
    localparam int COUNT_W         = 48;
    localparam int SQ_W            = 31;
    localparam int RMS_W           = 24;
    localparam int CFG_W           = 4;
    localparam int QDEPTH          = 2;
    localparam int DEF_BLK_LEN     = 1024;
    localparam int DEF_CHANNELS    = 4;
    localparam int IN_DATA_W       = 32;
    localparam int OUT_DATA_W      = 56;
    localparam int OUT_USER_W      = 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 19'sd262143;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -19'sd262144;
    localparam logic [RMS_W-1:0]        RMS_MAX = 24'd8388608;
    localparam logic [COUNT_W-1:0]      COUNT_MAX = '1;
    localparam logic [ENERGY_W-1:0]     ENERGY_MAX = '1;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_RMS  = 1'b1;

    // register indexes
    localparam logic REG_NUM_SOURCES = 1'b0;
    localparam logic REG_RMS_ENABLE  = 1'b1;

    typedef struct packed {
        logic                          op;
        logic                          ok;
        logic [SRC_W-1:0]              src;
        logic [CH_W-1:0]               ch;
        logic [POS_W-1:0]              pos;
        logic signed [SAMPLE_BITS-1:0] sample;
    } item_t;

    typedef struct packed {
        logic                    combined_valid;
        logic signed [SUM_W-1:0] combined_sample;
        logic [CH_W-1:0]         combined_channel;
        logic [POS_W-1:0]        combined_position;
        logic                    block_done;
        logic                    rms_valid;
        logic [RMS_W-1:0]        rms_value;
    } result_t;

    typedef struct packed {
        logic                start;
        logic [ENERGY_W-1:0] energy;
        logic [COUNT_W-1:0]  count;
        logic [NS_W-1:0]     ns;
    } rms_req_t;

    typedef struct packed {
        logic             done;
        logic             valid;
        logic [RMS_W-1:0] value;
    } rms_rsp_t;

endpackage

### design/msr_ram.sv
// generic single-port-write, registered-read ram
// no package dependencies
module msr_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/msr_front.sv
// front end: accepts beats, classifies them and queues them for the back end
// depends on msr_pkg
module msr_front #(
    parameter int BLK_LEN  = msr_pkg::DEF_BLK_LEN,
    parameter int CHANNELS = msr_pkg::DEF_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msr_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic [msr_pkg::NS_W-1:0]      num_sources,
    input  logic                          rms_enable,
    input  logic                          q_pop,
    output logic                          q_valid,
    output msr_pkg::item_t                q_item
);
    import msr_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t              mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    item_t              in_item;
    logic               push;
    logic               pop;
    logic               src_ok;
    logic               slot_ok;

    // unpack and classify the incoming beat
    always_comb
    begin
        in_item.op     = s_tuser;
        in_item.src    = s_tdata[2:0];
        in_item.ch     = s_tdata[4:3];
        in_item.pos    = s_tdata[14:5];
        in_item.sample = s_tdata[30:15];
        src_ok  = ({1'b0, in_item.src} < num_sources);
        slot_ok = (32'(in_item.ch) < CHANNELS) && (32'(in_item.pos) < BLK_LEN);
        if (in_item.op == OP_RMS)
        begin
            in_item.ok = src_ok && rms_enable;
        end
        else
        begin
            in_item.ok = src_ok && slot_ok;
        end
    end

    assign s_tready = (cnt_reg != CNT_W'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

### design/msr_rms_unit.sv
// iterative rms unit: count/sources, energy*65536/per and integer square root
// depends on msr_pkg
module msr_rms_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  msr_pkg::rms_req_t req,
    output msr_pkg::rms_rsp_t rsp
);
    import msr_pkg::*;

    localparam int Q_W   = ENERGY_W + 16;
    localparam int REM_W = COUNT_W + 1;
    localparam int SR_W  = RMS_W + 3;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_PER  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_SQRT = 2'd3;

    logic [1:0]          phase_reg, phase_next;
    logic [6:0]          step_reg, step_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [COUNT_W-1:0]  dvs_reg, dvs_next;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [SR_W-1:0]     srem_reg, srem_next;
    logic [RMS_W-1:0]    root_reg, root_next;
    rms_rsp_t            rsp_reg, rsp_next;

    logic [REM_W-1:0]    rem_sh;
    logic                d_ge;
    logic [REM_W-1:0]    d_rem;
    logic [Q_W-1:0]      d_q;
    logic [SR_W-1:0]     s_sh;
    logic [SR_W-1:0]     s_trial;
    logic                s_ge;
    logic [RMS_W-1:0]    s_root;

    // one restoring division step
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-2:0], q_reg[Q_W-1]};
        d_ge   = (rem_sh >= {1'b0, dvs_reg});
        d_rem  = d_ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
        d_q    = {q_reg[Q_W-2:0], d_ge};
    end

    // one square-root digit step
    always_comb
    begin
        s_sh    = {srem_reg[SR_W-3:0], q_reg[47:46]};
        s_trial = {1'b0, root_reg, 2'b01};
        s_ge    = (s_sh >= s_trial);
        s_root  = {root_reg[RMS_W-2:0], s_ge};
    end

    // sequencer
    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        dvs_next    = dvs_reg;
        energy_next = energy_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        rsp_next    = '0;
        unique case (phase_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    q_next      = {req.count, 32'b0};
                    rem_next    = '0;
                    dvs_next    = COUNT_W'(req.ns);
                    energy_next = req.energy;
                    step_next   = 7'(COUNT_W - 1);
                    phase_next  = U_PER;
                end
            end
            U_PER:
            begin
                rem_next = d_rem;
                q_next   = d_q;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (d_q[COUNT_W-1:0] == '0)
                    begin
                        rsp_next.done = 1'b1;
                        phase_next    = U_IDLE;
                    end
                    else
                    begin
                        dvs_next   = d_q[COUNT_W-1:0];
                        q_next     = {energy_reg, 16'b0};
                        rem_next   = '0;
                        step_next  = 7'(Q_W - 1);
                        phase_next = U_DIV;
                    end
                end
            end
            U_DIV:
            begin
                rem_next  = d_rem;
                q_next    = d_q;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (d_q[Q_W-1:46] != '0)
                    begin
                        rsp_next.done  = 1'b1;
                        rsp_next.valid = 1'b1;
                        rsp_next.value = RMS_MAX;
                        phase_next     = U_IDLE;
                    end
                    else
                    begin
                        srem_next  = '0;
                        root_next  = '0;
                        step_next  = 7'(RMS_W - 1);
                        phase_next = U_SQRT;
                    end
                end
            end
            U_SQRT:
            begin
                srem_next = s_ge ? s_sh - s_trial : s_sh;
                root_next = s_root;
                q_next    = {q_reg[Q_W-3:0], 2'b00};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    rsp_next.done  = 1'b1;
                    rsp_next.valid = 1'b1;
                    rsp_next.value = s_root;
                    phase_next     = U_IDLE;
                end
            end
            default:
            begin
                phase_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= U_IDLE;
            rsp_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rsp_reg   <= rsp_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        dvs_reg    <= dvs_next;
        energy_reg <= energy_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
    end

    assign rsp = rsp_reg;
endmodule

### design/msr_back.sv
// back end: sum store update, energy and count accumulation, result register
// depends on msr_pkg, msr_ram and msr_rms_unit
module msr_back #(
    parameter int BLK_LEN  = msr_pkg::DEF_BLK_LEN,
    parameter int CHANNELS = msr_pkg::DEF_CHANNELS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  msr_pkg::item_t           q_item,
    output logic                     q_pop,
    input  logic [msr_pkg::NS_W-1:0] num_sources,
    input  logic                     rms_enable,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output msr_pkg::result_t         result
);
    import msr_pkg::*;

    localparam int DEPTH = CHANNELS * BLK_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_SUM    = 2'd2;
    localparam logic [1:0] ST_WAIT   = 2'd3;

    logic [1:0]          state_reg, state_next;
    item_t               item_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [ENERGY_W-1:0] energy_reg [MAX_SOURCES];
    logic [COUNT_W-1:0]  count_reg;
    result_t             res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic [AW-1:0]          addr;
    logic [SUM_W-1:0]       rdata;
    logic                   ram_we;
    logic signed [SUM_W:0]  wide_sum;
    logic signed [SUM_W-1:0] sum;
    logic [ENERGY_W:0]      e_add;
    logic [ENERGY_W-1:0]    e_new;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic                   acc_en;
    logic                   is_last;
    rms_req_t               req;
    rms_rsp_t               rsp;

    assign addr = AW'(item_reg.ch) * AW'(BLK_LEN) + AW'(item_reg.pos);
    assign prod = item_reg.sample * item_reg.sample;

    msr_ram #(
        .WIDTH(SUM_W),
        .DEPTH(DEPTH)
    ) u_sums (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr),
        .wdata(sum),
        .raddr(addr),
        .rdata(rdata)
    );

    msr_rms_unit u_rms (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    // saturating sum and energy
    always_comb
    begin
        if (item_reg.src == '0)
        begin
            wide_sum = (SUM_W+1)'(item_reg.sample);
        end
        else
        begin
            wide_sum = (SUM_W+1)'($signed(rdata)) + (SUM_W+1)'(item_reg.sample);
        end
        if (wide_sum > (SUM_W+1)'(SUM_MAX))
        begin
            sum = SUM_MAX;
        end
        else if (wide_sum < (SUM_W+1)'(SUM_MIN))
        begin
            sum = SUM_MIN;
        end
        else
        begin
            sum = wide_sum[SUM_W-1:0];
        end
        e_add   = {1'b0, energy_reg[item_reg.src]} + (ENERGY_W+1)'(sq_reg);
        e_new   = e_add[ENERGY_W] ? ENERGY_MAX : e_add[ENERGY_W-1:0];
        is_last = ({1'b0, item_reg.src} == num_sources - 1'b1);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        acc_en         = 1'b0;
        req.start      = 1'b0;
        req.energy     = energy_reg[item_reg.src];
        req.count      = count_reg;
        req.ns         = num_sources;
        if (m_tvalid && m_tready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (item_reg.ok && item_reg.op == OP_PUSH)
                begin
                    state_next = ST_SUM;
                end
                else if (item_reg.ok)
                begin
                    req.start  = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    res_next       = '0;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                ram_we   = 1'b1;
                acc_en   = rms_enable;
                res_next = '0;
                if (is_last)
                begin
                    res_next.combined_valid    = 1'b1;
                    res_next.combined_sample   = sum;
                    res_next.combined_channel  = item_reg.ch;
                    res_next.combined_position = item_reg.pos;
                    res_next.block_done = (32'(item_reg.ch) == CHANNELS - 1) &&
                                          (32'(item_reg.pos) == BLK_LEN - 1);
                end
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    res_next           = '0;
                    res_next.rms_valid = rsp.valid;
                    res_next.rms_value = rsp.value;
                    res_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < MAX_SOURCES; i++)
            begin
                energy_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (acc_en)
            begin
                energy_reg[item_reg.src] <= e_new;
                if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_DECODE)
        begin
            sq_reg <= prod[SQ_W-1:0];
        end
    end

    assign m_tvalid = res_valid_reg;
    assign result   = res_reg;

    // a new item is taken only with the result slot empty
    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !res_valid_reg)
        else $error("item popped while result pending");

    // a result never answers both operations
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.combined_valid && res_reg.rms_valid))
        else $error("result marks both sum and rms");

    // end of block only on a finished sum
    a_done_sum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.block_done |-> res_reg.combined_valid)
        else $error("block end without combined sample");

    // rms answers arrive only while waiting on them
    a_rsp_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> state_reg == ST_WAIT)
        else $error("rms response outside wait");
endmodule

### design/multi_source_summer_with_rms.sv
// top level of the multi-source summer: configuration registers and wiring
// depends on msr_pkg, msr_front and msr_back
//
// channel   dir  beat content
// s_*       in   operation in tuser; source, channel, position, sample in tdata
// m_*       out  sum and rms flags in tuser; block end in tlast; values in tdata
// cfg_*     in   register write: index 0 num_sources, index 1 rms_enable
//
// a push passes through the back end in three steps (pop, sum store read, update); the next
// beat is popped only once the result has been taken
// an rms read runs pop, decode, 48 + 80 division steps, 24 root steps and the pickup
// of the answer; it stops after the first 48 steps when no per-source count is there yet
// a two-beat queue lets the front keep accepting while the back end stalls
// reset is asynchronous; no clearing pass, the sum store is undefined until written
module multi_source_summer_with_rms #(
    parameter int BLK_LEN  = msr_pkg::DEF_BLK_LEN,
    parameter int CHANNELS = msr_pkg::DEF_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // source_index, channel, position, sample, zero pad
    input  logic [msr_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // combined_sample, combined_channel, combined_position, rms_value, zero pad
    output logic [msr_pkg::OUT_DATA_W-1:0] m_tdata,
    // combined_valid, rms_valid
    output logic [msr_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [msr_pkg::CFG_W-1:0]      cfg_wdata
);
    import msr_pkg::*;

    logic [NS_W-1:0] num_sources_reg;
    logic            rms_enable_reg;
    logic [NS_W-1:0] ns_eff;
    logic            q_valid;
    logic            q_pop;
    item_t           q_item;
    result_t         result;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sources_reg <= NS_W'(1);
            rms_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_NUM_SOURCES: num_sources_reg <= cfg_wdata[NS_W-1:0];
                REG_RMS_ENABLE:  rms_enable_reg  <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // clamp source count to the supported range
    always_comb
    begin
        if (num_sources_reg == '0)
        begin
            ns_eff = NS_W'(1);
        end
        else if (32'(num_sources_reg) > MAX_SOURCES)
        begin
            ns_eff = NS_W'(MAX_SOURCES);
        end
        else
        begin
            ns_eff = num_sources_reg;
        end
    end

    msr_front #(
        .BLK_LEN (BLK_LEN),
        .CHANNELS(CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .num_sources(ns_eff),
        .rms_enable (rms_enable_reg),
        .q_pop      (q_pop),
        .q_valid    (q_valid),
        .q_item     (q_item)
    );

    msr_back #(
        .BLK_LEN (BLK_LEN),
        .CHANNELS(CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .num_sources(ns_eff),
        .rms_enable (rms_enable_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    // output beat packing
    assign m_tdata = {1'b0, result.rms_value, result.combined_position,
                      result.combined_channel, result.combined_sample};
    assign m_tuser = {result.rms_valid, result.combined_valid};
    assign m_tlast = result.block_done;
endmodule
